// File: hdl/lav_pkg.sv
// Shared constants, the matrix bundle type and the rounding helper of the look-at core.
package lav_pkg;

    localparam int DATA_W          = 32;
    localparam int NORM_W          = 30;
    localparam int NORM_MSB        = 29;
    localparam int SQ_W            = 62;
    localparam int LEN_W           = 31;
    localparam int ISQ_STEPS       = LEN_W;
    localparam int RND_W           = 72;
    localparam int ROWS            = 4;
    localparam int ROW_W           = 2;
    localparam int CYCLES_PER_ITEM = 4;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    typedef struct packed {
        logic [ROWS-1:0][DATA_W-1:0] col0;
        logic [ROWS-1:0][DATA_W-1:0] col1;
        logic [ROWS-1:0][DATA_W-1:0] col2;
        logic [ROWS-1:0][DATA_W-1:0] col3;
        logic                        deg;
    } t_mat;

    // Rounds a value with twice the fraction bits to nearest, ties away from zero,
    // and saturates to the signed 32-bit range.
    function automatic logic [DATA_W-1:0] round_sat(input logic signed [RND_W-1:0] v,
                                                    input int unsigned frac);
        logic [RND_W-1:0] mag;
        logic [RND_W-1:0] m;
        logic [RND_W-1:0] res;
        mag = v[RND_W-1] ? (~v + RND_W'(1)) : v;
        m   = (mag + (RND_W'(1) << (frac - 1))) >> frac;
        if (v[RND_W-1]) begin
            if (m > RND_W'(64'h8000_0000)) begin
                res = RND_W'(64'h8000_0000);
            end else begin
                res = ~m + RND_W'(1);
            end
        end else begin
            if (m > RND_W'(64'h7FFF_FFFF)) begin
                res = RND_W'(64'h7FFF_FFFF);
            end else begin
                res = m;
            end
        end
        return res[DATA_W-1:0];
    endfunction

endpackage

// File: hdl/look_at_view_matrix_core.sv
// Right-handed look-at view matrix core: forward, side and up vectors, then four rows.
// Row 0 comes first on the outputs and rows 1 to 3 follow on successive cycles; each row is
// one cycle long. Busy is high after each transfer and holds off the next item until the
// spacing counter runs out, as set by the four-row output sequence; earlier items may still
// be in the pipeline then. The two normalisers hold one root stage per result bit.
// Synchronous active-low reset clears all valid bits and counters; the outputs never stall.
module look_at_view_matrix_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [lav_pkg::DATA_W-1:0] i_eye_x,
    input  logic signed [lav_pkg::DATA_W-1:0] i_eye_y,
    input  logic signed [lav_pkg::DATA_W-1:0] i_eye_z,
    input  logic signed [lav_pkg::DATA_W-1:0] i_target_x,
    input  logic signed [lav_pkg::DATA_W-1:0] i_target_y,
    input  logic signed [lav_pkg::DATA_W-1:0] i_target_z,
    input  logic signed [lav_pkg::DATA_W-1:0] i_up_x,
    input  logic signed [lav_pkg::DATA_W-1:0] i_up_y,
    input  logic signed [lav_pkg::DATA_W-1:0] i_up_z,
    output logic                              o_valid,
    output logic [lav_pkg::ROW_W-1:0]         o_row_index,
    output logic signed [lav_pkg::DATA_W-1:0] o_entry_col0,
    output logic signed [lav_pkg::DATA_W-1:0] o_entry_col1,
    output logic signed [lav_pkg::DATA_W-1:0] o_entry_col2,
    output logic signed [lav_pkg::DATA_W-1:0] o_entry_col3,
    output logic                              o_last_row,
    output logic                              o_degenerate
);
    import lav_pkg::*;

    localparam int FW      = FRAC_BITS + 2;
    localparam int D_W     = DATA_W + 1;
    localparam int PF_W    = FW + DATA_W;
    localparam int RAW_W   = PF_W + 1;
    localparam int SIDE1_W = 6 * DATA_W;
    localparam int SIDE2_W = 3 * DATA_W + 3 * FW + 1;
    localparam int SF_W    = 2 * FW;
    localparam int U_W     = SF_W + 1;
    localparam int DS_W    = PF_W + 2;
    localparam int UE_W    = 2 * DATA_W;
    localparam int DUE_W   = UE_W + 2;
    localparam int GAP_W   = $clog2(CYCLES_PER_ITEM);

    logic [GAP_W-1:0] r_gap, n_gap;
    logic             w_accept;

    logic                     r0_vld;
    logic signed [DATA_W-1:0] r0_eye [3];
    logic signed [DATA_W-1:0] r0_tgt [3];
    logic signed [DATA_W-1:0] r0_up [3];

    logic                     r1_vld;
    logic signed [D_W-1:0]    r1_d [3];
    logic [SIDE1_W-1:0]       r1_side, n1_side;

    logic                     w_f_vld, w_zf;
    logic signed [FW-1:0]     w_f [3];
    logic [SIDE1_W-1:0]       w_side1;
    logic signed [DATA_W-1:0] w_eye1 [3];
    logic signed [DATA_W-1:0] w_up1 [3];

    logic                     rc1_vld, rc1_zf;
    logic signed [PF_W-1:0]   rc1_p [6];
    logic signed [FW-1:0]     rc1_f [3];
    logic signed [DATA_W-1:0] rc1_eye [3];

    logic                     rc2_vld;
    logic signed [RAW_W-1:0]  rc2_raw [3];
    logic [SIDE2_W-1:0]       rc2_side, nc2_side;

    logic                     w_s_vld, w_zs;
    logic signed [FW-1:0]     w_s [3];
    logic [SIDE2_W-1:0]       w_side2;
    logic signed [DATA_W-1:0] w_eye2 [3];
    logic signed [FW-1:0]     w_f2 [3];

    logic                     rd1_vld, rd1_deg;
    logic signed [SF_W-1:0]   rd1_sf [6];
    logic signed [PF_W-1:0]   rd1_se [3];
    logic signed [PF_W-1:0]   rd1_fe [3];
    logic signed [FW-1:0]     rd1_s [3];
    logic signed [FW-1:0]     rd1_f [3];
    logic signed [DATA_W-1:0] rd1_eye [3];

    logic                     rd2_vld, rd2_deg;
    logic signed [U_W-1:0]    rd2_uraw [3];
    logic signed [DS_W-1:0]   rd2_ds, rd2_df;
    logic signed [FW-1:0]     rd2_s [3];
    logic signed [FW-1:0]     rd2_f [3];
    logic signed [DATA_W-1:0] rd2_eye [3];

    logic                     rd3_vld, rd3_deg;
    logic signed [DATA_W-1:0] rd3_u [3];
    logic signed [DATA_W-1:0] rd3_r30, rd3_r32;
    logic signed [FW-1:0]     rd3_s [3];
    logic signed [FW-1:0]     rd3_f [3];
    logic signed [DATA_W-1:0] rd3_eye [3];

    logic                     rd4_vld, rd4_deg;
    logic signed [UE_W-1:0]   rd4_ue [3];
    logic signed [DATA_W-1:0] rd4_u [3];
    logic signed [DATA_W-1:0] rd4_r30, rd4_r32;
    logic signed [FW-1:0]     rd4_s [3];
    logic signed [FW-1:0]     rd4_f [3];

    logic                     rd5_vld, rd5_deg;
    logic signed [DUE_W-1:0]  rd5_due;
    logic signed [DATA_W-1:0] rd5_u [3];
    logic signed [DATA_W-1:0] rd5_r30, rd5_r32;
    logic signed [FW-1:0]     rd5_s [3];
    logic signed [FW-1:0]     rd5_f [3];

    logic                     r_mat_vld;
    t_mat                     r_mat, n_mat;

    // Issue spacing: busy blocks a new transfer until the gap counter has run down to zero.
    assign w_accept = start && !busy;
    assign busy     = (r_gap != '0);

    always_comb begin
        if (w_accept) begin
            n_gap = GAP_W'(CYCLES_PER_ITEM - 1);
        end else if (r_gap != '0) begin
            n_gap = r_gap - GAP_W'(1);
        end else begin
            n_gap = r_gap;
        end
    end

    always_comb begin
        n1_side = '0;
        for (int i = 0; i < 3; i++) begin
            n1_side[SIDE1_W-1-i*DATA_W -: DATA_W]     = r0_eye[i];
            n1_side[SIDE1_W-1-(i+3)*DATA_W -: DATA_W] = r0_up[i];
        end
        for (int i = 0; i < 3; i++) begin
            w_eye1[i] = w_side1[SIDE1_W-1-i*DATA_W -: DATA_W];
            w_up1[i]  = w_side1[SIDE1_W-1-(i+3)*DATA_W -: DATA_W];
        end
    end

    always_comb begin
        nc2_side = '0;
        for (int i = 0; i < 3; i++) begin
            nc2_side[SIDE2_W-1-i*DATA_W -: DATA_W]          = rc1_eye[i];
            nc2_side[SIDE2_W-1-3*DATA_W-i*FW -: FW]         = rc1_f[i];
        end
        nc2_side[0] = rc1_zf;
        for (int i = 0; i < 3; i++) begin
            w_eye2[i] = w_side2[SIDE2_W-1-i*DATA_W -: DATA_W];
            w_f2[i]   = w_side2[SIDE2_W-1-3*DATA_W-i*FW -: FW];
        end
    end

    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (D_W),
        .SIDE_W    (SIDE1_W)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_vld),
        .i_c     (r1_d),
        .i_side  (r1_side),
        .o_valid (w_f_vld),
        .o_n     (w_f),
        .o_zero  (w_zf),
        .o_side  (w_side1)
    );

    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (RAW_W),
        .SIDE_W    (SIDE2_W)
    ) u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rc2_vld),
        .i_c     (rc2_raw),
        .i_side  (rc2_side),
        .o_valid (w_s_vld),
        .o_n     (w_s),
        .o_zero  (w_zs),
        .o_side  (w_side2)
    );

    always_comb begin
        n_mat     = '0;
        n_mat.deg = rd5_deg;
        for (int i = 0; i < 3; i++) begin
            n_mat.col0[i] = DATA_W'(rd5_s[i]);
            n_mat.col1[i] = rd5_u[i];
            n_mat.col2[i] = -DATA_W'(rd5_f[i]);
            n_mat.col3[i] = '0;
        end
        n_mat.col0[ROWS-1] = rd5_r30;
        n_mat.col1[ROWS-1] = round_sat(-RND_W'(rd5_due), FRAC_BITS);
        n_mat.col2[ROWS-1] = rd5_r32;
        n_mat.col3[ROWS-1] = DATA_W'(1) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap     <= '0;
            r0_vld    <= 1'b0;
            r1_vld    <= 1'b0;
            rc1_vld   <= 1'b0;
            rc2_vld   <= 1'b0;
            rd1_vld   <= 1'b0;
            rd2_vld   <= 1'b0;
            rd3_vld   <= 1'b0;
            rd4_vld   <= 1'b0;
            rd5_vld   <= 1'b0;
            r_mat_vld <= 1'b0;
        end else begin
            r_gap     <= n_gap;
            r0_vld    <= w_accept;
            r1_vld    <= r0_vld;
            rc1_vld   <= w_f_vld;
            rc2_vld   <= rc1_vld;
            rd1_vld   <= w_s_vld;
            rd2_vld   <= rd1_vld;
            rd3_vld   <= rd2_vld;
            rd4_vld   <= rd3_vld;
            rd5_vld   <= rd4_vld;
            r_mat_vld <= rd5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r0_eye[0] <= i_eye_x;
            r0_eye[1] <= i_eye_y;
            r0_eye[2] <= i_eye_z;
            r0_tgt[0] <= i_target_x;
            r0_tgt[1] <= i_target_y;
            r0_tgt[2] <= i_target_z;
            r0_up[0]  <= i_up_x;
            r0_up[1]  <= i_up_y;
            r0_up[2]  <= i_up_z;
        end
        for (int i = 0; i < 3; i++) begin
            r1_d[i] <= D_W'(r0_tgt[i]) - D_W'(r0_eye[i]);
        end
        r1_side <= n1_side;

        // Forward cross approximate up, products first.
        rc1_p[0] <= w_f[1] * w_up1[2];
        rc1_p[1] <= w_f[2] * w_up1[1];
        rc1_p[2] <= w_f[2] * w_up1[0];
        rc1_p[3] <= w_f[0] * w_up1[2];
        rc1_p[4] <= w_f[0] * w_up1[1];
        rc1_p[5] <= w_f[1] * w_up1[0];
        rc1_f    <= w_f;
        rc1_eye  <= w_eye1;
        rc1_zf   <= w_zf;

        for (int i = 0; i < 3; i++) begin
            rc2_raw[i] <= RAW_W'(rc1_p[2*i]) - RAW_W'(rc1_p[2*i+1]);
        end
        rc2_side <= nc2_side;

        rd1_sf[0] <= w_s[1] * w_f2[2];
        rd1_sf[1] <= w_s[2] * w_f2[1];
        rd1_sf[2] <= w_s[2] * w_f2[0];
        rd1_sf[3] <= w_s[0] * w_f2[2];
        rd1_sf[4] <= w_s[0] * w_f2[1];
        rd1_sf[5] <= w_s[1] * w_f2[0];
        for (int i = 0; i < 3; i++) begin
            rd1_se[i] <= w_s[i] * w_eye2[i];
            rd1_fe[i] <= w_f2[i] * w_eye2[i];
        end
        rd1_s   <= w_s;
        rd1_f   <= w_f2;
        rd1_eye <= w_eye2;
        rd1_deg <= w_zs | w_side2[0];

        for (int i = 0; i < 3; i++) begin
            rd2_uraw[i] <= U_W'(rd1_sf[2*i]) - U_W'(rd1_sf[2*i+1]);
        end
        rd2_ds  <= DS_W'(rd1_se[0]) + DS_W'(rd1_se[1]) + DS_W'(rd1_se[2]);
        rd2_df  <= DS_W'(rd1_fe[0]) + DS_W'(rd1_fe[1]) + DS_W'(rd1_fe[2]);
        rd2_s   <= rd1_s;
        rd2_f   <= rd1_f;
        rd2_eye <= rd1_eye;
        rd2_deg <= rd1_deg;

        for (int i = 0; i < 3; i++) begin
            rd3_u[i] <= round_sat(RND_W'(rd2_uraw[i]), FRAC_BITS);
        end
        rd3_r30 <= round_sat(-RND_W'(rd2_ds), FRAC_BITS);
        rd3_r32 <= round_sat(RND_W'(rd2_df), FRAC_BITS);
        rd3_s   <= rd2_s;
        rd3_f   <= rd2_f;
        rd3_eye <= rd2_eye;
        rd3_deg <= rd2_deg;

        for (int i = 0; i < 3; i++) begin
            rd4_ue[i] <= rd3_u[i] * rd3_eye[i];
        end
        rd4_u   <= rd3_u;
        rd4_r30 <= rd3_r30;
        rd4_r32 <= rd3_r32;
        rd4_s   <= rd3_s;
        rd4_f   <= rd3_f;
        rd4_deg <= rd3_deg;

        rd5_due <= DUE_W'(rd4_ue[0]) + DUE_W'(rd4_ue[1]) + DUE_W'(rd4_ue[2]);
        rd5_u   <= rd4_u;
        rd5_r30 <= rd4_r30;
        rd5_r32 <= rd4_r32;
        rd5_s   <= rd4_s;
        rd5_f   <= rd4_f;
        rd5_deg <= rd4_deg;

        r_mat   <= n_mat;
    end

    lav_rows u_rows (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_mat_vld),
        .i_mat        (r_mat),
        .o_valid      (o_valid),
        .o_row_index  (o_row_index),
        .o_entry_col0 (o_entry_col0),
        .o_entry_col1 (o_entry_col1),
        .o_entry_col2 (o_entry_col2),
        .o_entry_col3 (o_entry_col3),
        .o_last_row   (o_last_row),
        .o_degenerate (o_degenerate)
    );

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a transfer");

    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_row_index != LAST_ROW)) |=>
        (o_valid && (o_row_index == $past(o_row_index) + ROW_W'(1))))
        else $error("rows of a matrix were not sent on consecutive cycles");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row == (o_row_index == LAST_ROW)))
        else $error("last row flag does not match the row index");

    a_col3_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_row) |-> (o_entry_col3 == '0))
        else $error("column 3 is not zero on a rotation row");

    a_deg_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_row) |=> $stable(o_degenerate))
        else $error("degenerate flag changed within one matrix");

endmodule

// File: hdl/lav_norm.sv
// Pipelined vector normaliser: scaling, squares, digit-by-digit root and long division.
module lav_norm #(
    parameter int FRAC_BITS = 16,
    parameter int IN_W      = 33,
    parameter int SIDE_W    = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [IN_W-1:0]      i_c [3],
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic signed [FRAC_BITS+1:0] o_n [3],
    output logic                        o_zero,
    output logic [SIDE_W-1:0]           o_side
);
    import lav_pkg::*;

    localparam int P_W   = $clog2(IN_W);
    localparam int OUT_W = FRAC_BITS + 2;
    localparam int QW    = FRAC_BITS + 1;
    localparam int NUM_W = NORM_W + FRAC_BITS + 1;

    typedef struct packed {
        logic                         vld;
        logic [2:0][NORM_W-1:0]       m;
        logic [2:0]                   neg;
        logic                         zero;
        logic [SIDE_W-1:0]            side;
        logic [SQ_W-1:0]              v;
        logic [SQ_W-1:0]              r;
    } t_isq;

    typedef struct packed {
        logic                         vld;
        logic [2:0]                   neg;
        logic                         zero;
        logic [SIDE_W-1:0]            side;
        logic [LEN_W-1:0]             len;
        logic [2:0][LEN_W-1:0]        rem;
        logic [2:0][QW-1:0]           low;
        logic [2:0][QW-1:0]           q;
    } t_div;

    // Stage 1: magnitudes and signs.
    logic                   r1_vld, n1_vld;
    logic [IN_W-1:0]        r1_m [3];
    logic [IN_W-1:0]        n1_m [3];
    logic [2:0]             r1_neg, n1_neg;
    logic [SIDE_W-1:0]      r1_side;

    // Stage 2: leading one of the largest magnitude.
    logic                   r2_vld;
    logic [IN_W-1:0]        r2_m [3];
    logic [2:0]             r2_neg;
    logic                   r2_zero, n2_zero;
    logic [P_W-1:0]         r2_p, n2_p;
    logic [SIDE_W-1:0]      r2_side;
    logic [IN_W-1:0]        w_or;

    // Stage 3: scaled magnitudes.
    logic                   r3_vld;
    logic [NORM_W-1:0]      r3_m [3];
    logic [NORM_W-1:0]      n3_m [3];
    logic [2:0]             r3_neg;
    logic                   r3_zero;
    logic [SIDE_W-1:0]      r3_side;

    // Stage 4: squares.
    logic                   r4_vld;
    logic [NORM_W-1:0]      r4_m [3];
    logic [2*NORM_W-1:0]    r4_sq [3];
    logic [2:0]             r4_neg;
    logic                   r4_zero;
    logic [SIDE_W-1:0]      r4_side;

    t_isq r_isq [ISQ_STEPS+1];
    t_isq n_isq [ISQ_STEPS+1];
    t_div r_div [QW+1];
    t_div n_div [QW+1];

    logic                   r_out_vld;
    logic [OUT_W-1:0]       r_out_n [3];
    logic [OUT_W-1:0]       n_out_n [3];
    logic                   r_out_zero;
    logic [SIDE_W-1:0]      r_out_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_neg[i] = i_c[i][IN_W-1];
            n1_m[i]   = i_c[i][IN_W-1] ? (~i_c[i] + IN_W'(1)) : i_c[i];
        end
        n1_vld = i_valid;
    end

    always_comb begin
        w_or    = r1_m[0] | r1_m[1] | r1_m[2];
        n2_zero = (w_or == '0);
        n2_p    = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (w_or[b]) begin
                n2_p = P_W'(b);
            end
        end
    end

    always_comb begin
        logic [IN_W-1:0] t;
        for (int i = 0; i < 3; i++) begin
            if (r2_p >= P_W'(NORM_MSB)) begin
                t = r2_m[i] >> (r2_p - P_W'(NORM_MSB));
            end else begin
                t = r2_m[i] << (P_W'(NORM_MSB) - r2_p);
            end
            n3_m[i] = t[NORM_W-1:0];
        end
    end

    // Root: one result bit per stage, starting at the top power of four.
    always_comb begin
        logic [SQ_W:0]   t;
        logic [SQ_W-1:0] b;
        n_isq[0].vld  = r4_vld;
        n_isq[0].neg  = r4_neg;
        n_isq[0].zero = r4_zero;
        n_isq[0].side = r4_side;
        for (int i = 0; i < 3; i++) begin
            n_isq[0].m[i] = r4_m[i];
        end
        n_isq[0].v = SQ_W'(r4_sq[0]) + SQ_W'(r4_sq[1]) + SQ_W'(r4_sq[2]);
        n_isq[0].r = '0;
        for (int j = 0; j < ISQ_STEPS; j++) begin
            b            = SQ_W'(1) << (2 * (ISQ_STEPS - 1 - j));
            n_isq[j+1]   = r_isq[j];
            t            = {1'b0, r_isq[j].r} + {1'b0, b};
            if ({1'b0, r_isq[j].v} >= t) begin
                n_isq[j+1].v = r_isq[j].v - t[SQ_W-1:0];
                n_isq[j+1].r = (r_isq[j].r >> 1) + b;
            end else begin
                n_isq[j+1].r = r_isq[j].r >> 1;
            end
        end
    end

    // Division: the quotient fits QW bits, so only the low QW dividend bits are walked.
    always_comb begin
        logic [NUM_W-1:0] num;
        logic [LEN_W:0]   tr;
        n_div[0].vld  = r_isq[ISQ_STEPS].vld;
        n_div[0].neg  = r_isq[ISQ_STEPS].neg;
        n_div[0].zero = r_isq[ISQ_STEPS].zero;
        n_div[0].side = r_isq[ISQ_STEPS].side;
        n_div[0].len  = r_isq[ISQ_STEPS].r[LEN_W-1:0];
        for (int i = 0; i < 3; i++) begin
            num = (NUM_W'(r_isq[ISQ_STEPS].m[i]) << FRAC_BITS)
                + NUM_W'(r_isq[ISQ_STEPS].r[LEN_W-1:1]);
            n_div[0].rem[i] = LEN_W'(num[NUM_W-1:QW]);
            n_div[0].low[i] = num[QW-1:0];
            n_div[0].q[i]   = '0;
        end
        for (int j = 0; j < QW; j++) begin
            n_div[j+1] = r_div[j];
            for (int i = 0; i < 3; i++) begin
                tr = {r_div[j].rem[i], r_div[j].low[i][QW-1-j]};
                if (tr >= {1'b0, r_div[j].len}) begin
                    tr                      = tr - {1'b0, r_div[j].len};
                    n_div[j+1].q[i][QW-1-j] = 1'b1;
                end
                n_div[j+1].rem[i] = tr[LEN_W-1:0];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_div[QW].zero) begin
                n_out_n[i] = '0;
            end else if (r_div[QW].neg[i]) begin
                n_out_n[i] = ~OUT_W'(r_div[QW].q[i]) + OUT_W'(1);
            end else begin
                n_out_n[i] = OUT_W'(r_div[QW].q[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r1_vld    <= n1_vld;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r_out_vld <= r_div[QW].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= ISQ_STEPS; j++) begin
                r_isq[j].vld <= 1'b0;
            end
            for (int j = 0; j <= QW; j++) begin
                r_div[j].vld <= 1'b0;
            end
        end else begin
            r_isq <= n_isq;
            r_div <= n_div;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_m       <= n1_m;
        r1_neg     <= n1_neg;
        r1_side    <= i_side;
        r2_m       <= r1_m;
        r2_neg     <= r1_neg;
        r2_zero    <= n2_zero;
        r2_p       <= n2_p;
        r2_side    <= r1_side;
        r3_m       <= n3_m;
        r3_neg     <= r2_neg;
        r3_zero    <= r2_zero;
        r3_side    <= r2_side;
        r4_m       <= r3_m;
        r4_neg     <= r3_neg;
        r4_zero    <= r3_zero;
        r4_side    <= r3_side;
        for (int i = 0; i < 3; i++) begin
            r4_sq[i] <= r3_m[i] * r3_m[i];
        end
        r_out_n    <= n_out_n;
        r_out_zero <= r_div[QW].zero;
        r_out_side <= r_div[QW].side;
    end

    assign o_valid = r_out_vld;
    assign o_zero  = r_out_zero;
    assign o_side  = r_out_side;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_n[i] = r_out_n[i];
        end
    end

endmodule

// File: hdl/lav_rows.sv
// Row sequencer: holds one finished matrix and sends its four rows on successive cycles.
module lav_rows (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  lav_pkg::t_mat               i_mat,
    output logic                        o_valid,
    output logic [lav_pkg::ROW_W-1:0]   o_row_index,
    output logic [lav_pkg::DATA_W-1:0]  o_entry_col0,
    output logic [lav_pkg::DATA_W-1:0]  o_entry_col1,
    output logic [lav_pkg::DATA_W-1:0]  o_entry_col2,
    output logic [lav_pkg::DATA_W-1:0]  o_entry_col3,
    output logic                        o_last_row,
    output logic                        o_degenerate
);
    import lav_pkg::*;

    logic              r_act, n_act;
    logic [ROW_W-1:0]  r_row, n_row;
    t_mat              r_mat;
    logic              r_ovld;
    logic [ROW_W-1:0]  r_orow;
    logic [DATA_W-1:0] r_oc0, r_oc1, r_oc2, r_oc3;
    logic              r_olast, r_odeg;

    // A new matrix may arrive in the cycle that sends the last row of the previous one.
    always_comb begin
        n_act = i_valid | (r_act & (r_row != LAST_ROW));
        if (i_valid) begin
            n_row = '0;
        end else if (r_act) begin
            n_row = r_row + ROW_W'(1);
        end else begin
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_row  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_act  <= n_act;
            r_row  <= n_row;
            r_ovld <= r_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_mat <= i_mat;
        end
        r_orow  <= r_row;
        r_oc0   <= r_mat.col0[r_row];
        r_oc1   <= r_mat.col1[r_row];
        r_oc2   <= r_mat.col2[r_row];
        r_oc3   <= r_mat.col3[r_row];
        r_olast <= (r_row == LAST_ROW);
        r_odeg  <= r_mat.deg;
    end

    assign o_valid      = r_ovld;
    assign o_row_index  = r_orow;
    assign o_entry_col0 = r_oc0;
    assign o_entry_col1 = r_oc1;
    assign o_entry_col2 = r_oc2;
    assign o_entry_col3 = r_oc3;
    assign o_last_row   = r_olast;
    assign o_degenerate = r_odeg;

endmodule

// File: test/tb.sv
// Self-checking testbench of the look-at view matrix core with a directed table and random cameras.
`timescale 1ns / 1ps

module tb;
    import lav_pkg::*;

    localparam int FRAC      = 16;
    localparam int N_RANDOM  = 300;
    localparam int IDLE_MAX  = 3000;
    localparam int DRAIN     = 200;
    localparam longint ONE   = longint'(1) << FRAC;

    typedef struct {
        logic [ROW_W-1:0]  row;
        logic [DATA_W-1:0] c0;
        logic [DATA_W-1:0] c1;
        logic [DATA_W-1:0] c2;
        logic [DATA_W-1:0] c3;
        logic              last;
        logic              deg;
    } t_row;

    // One table row: the nine input fields and whether the degenerate zero matrix is expected.
    typedef struct {
        logic signed [DATA_W-1:0] v[9];
        bit                       zero_mat;
    } t_cam;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] cam[9];
    logic                     o_valid;
    logic [ROW_W-1:0]         o_row_index;
    logic signed [DATA_W-1:0] o_entry_col0;
    logic signed [DATA_W-1:0] o_entry_col1;
    logic signed [DATA_W-1:0] o_entry_col2;
    logic signed [DATA_W-1:0] o_entry_col3;
    logic                     o_last_row;
    logic                     o_degenerate;

    t_row rows_due[$];
    int   n_err;
    int   idle_cycles;

    look_at_view_matrix_core #(.FRAC_BITS(FRAC)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_eye_x     (cam[0]),
        .i_eye_y     (cam[1]),
        .i_eye_z     (cam[2]),
        .i_target_x  (cam[3]),
        .i_target_y  (cam[4]),
        .i_target_z  (cam[5]),
        .i_up_x      (cam[6]),
        .i_up_y      (cam[7]),
        .i_up_z      (cam[8]),
        .o_valid     (o_valid),
        .o_row_index (o_row_index),
        .o_entry_col0(o_entry_col0),
        .o_entry_col1(o_entry_col1),
        .o_entry_col2(o_entry_col2),
        .o_entry_col3(o_entry_col3),
        .o_last_row  (o_last_row),
        .o_degenerate(o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = longint'(1) << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned magn(input longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    // Scales the vector so its largest magnitude lies in [2^29, 2^30), then divides by the root.
    function automatic bit unit_vec(input longint c[3], output longint n[3]);
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned len;
        longint unsigned q;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = magn(c[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            n = '{0, 0, 0};
            return 1'b1;
        end
        while (mx >= (longint'(1) << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (longint'(1) << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC) + (len >> 1)) / len;
            n[i] = c[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b0;
    endfunction

    function automatic void cross_prod(input longint a[3], input longint b[3],
                                       output longint r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Drops the extra fraction bits, nearest with ties away from zero, and clamps to 32 bits.
    function automatic logic [DATA_W-1:0] to_frac(input longint v);
        longint unsigned m;
        m = (magn(v) + (longint'(1) << (FRAC - 1))) >> FRAC;
        if (v < 0) return m > 64'h8000_0000 ? 32'h8000_0000 : DATA_W'(-longint'(m));
        return m > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : DATA_W'(m);
    endfunction

    function automatic longint dot_prod(input longint a[3], input longint b[3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    task automatic predict_view(input logic signed [DATA_W-1:0] v[9]);
        longint eye[3], up[3], dir[3], fw[3], sd[3], tu[3], raw[3];
        logic [DATA_W-1:0] u32[3];
        logic [DATA_W-1:0] last3[3];
        bit deg;
        t_row r;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'(v[i]);
            dir[i] = longint'(v[3 + i]) - eye[i];
            up[i]  = longint'(v[6 + i]);
        end
        deg = unit_vec(dir, fw);
        cross_prod(fw, up, raw);
        if (unit_vec(raw, sd)) deg = 1'b1;
        cross_prod(sd, fw, raw);
        for (int i = 0; i < 3; i++) begin
            u32[i] = to_frac(raw[i]);
            tu[i]  = longint'($signed(u32[i]));
        end
        last3[0] = to_frac(-dot_prod(sd, eye));
        last3[1] = to_frac(-dot_prod(tu, eye));
        last3[2] = to_frac(dot_prod(fw, eye));
        for (int i = 0; i < ROWS; i++) begin
            r.row  = ROW_W'(i);
            r.last = (i == ROWS - 1);
            r.deg  = deg;
            if (i < 3) begin
                r.c0 = DATA_W'(sd[i]);
                r.c1 = u32[i];
                r.c2 = DATA_W'(-fw[i]);
                r.c3 = '0;
            end else begin
                r.c0 = last3[0];
                r.c1 = last3[1];
                r.c2 = last3[2];
                r.c3 = DATA_W'(ONE);
            end
            rows_due.push_back(r);
        end
    endtask

    // The zero matrix with the degenerate flag: only row 3 carries the one.
    task automatic expect_zero_matrix();
        t_row r;
        for (int i = 0; i < ROWS; i++) begin
            r = '{ROW_W'(i), '0, '0, '0, (i == ROWS - 1) ? DATA_W'(ONE) : '0,
                  (i == ROWS - 1), 1'b1};
            rows_due.push_back(r);
        end
    endtask

    function automatic int pick_gap(input bit quiet);
        int p;
        if (quiet) return 0;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Presents one camera and holds it until the core takes it; start stays high if no gap follows.
    task automatic send_cam(input t_cam c, input bit quiet, input bit last_one);
        int gap;
        cam   <= c.v;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (c.zero_mat) expect_zero_matrix();
        else predict_view(c.v);
        gap = last_one ? 1 : pick_gap(quiet);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] rnd_field(input int kind);
        case (kind)
            0: return $urandom;
            1: return $signed($urandom_range(0, 2 * 8 * 65536)) - 8 * 65536;
            2: return $signed($urandom_range(0, 2 * 1024 * 65536)) - 1024 * 65536;
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (rows_due.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected row %0d at %0t", o_row_index, $realtime);
            end else begin
                t_row e;
                e = rows_due.pop_front();
                if (o_row_index !== e.row || o_entry_col0 !== e.c0 || o_entry_col1 !== e.c1
                    || o_entry_col2 !== e.c2 || o_entry_col3 !== e.c3
                    || o_last_row !== e.last || o_degenerate !== e.deg) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("row mismatch: exp %0d %h %h %h %h %b %b", e.row, e.c0, e.c1,
                                 e.c2, e.c3, e.last, e.deg);
                        $display("              got %0d %h %h %h %h %b %b", o_row_index,
                                 o_entry_col0, o_entry_col1, o_entry_col2, o_entry_col3,
                                 o_last_row, o_degenerate);
                    end
                end
            end
        end
    end

    // Watchdog: cycles with neither an input transfer nor a result reset nothing.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_MAX) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_cam tab[$];
        t_cam c;
        bit   quiet;
        int   kind;
        n_err       = 0;
        idle_cycles = 0;
        start       = 1'b0;
        i_rst_n     = 1'b0;
        for (int i = 0; i < 9; i++) cam[i] = '0;

        // eye, target, up; fields in Q16.16
        tab.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1});
        tab.push_back('{'{5 << 16, -3 << 16, 7 << 16, 5 << 16, -3 << 16, 7 << 16,
                          0, 1 << 16, 0}, 1'b1});
        tab.push_back('{'{0, 0, 5 << 16, 0, 0, 0, 0, 1 << 16, 0}, 1'b0});
        tab.push_back('{'{1 << 16, 2 << 16, 3 << 16, 0, 0, 0, 0, 0, 1 << 16}, 1'b0});
        // Up parallel to the view direction leaves no side vector.
        tab.push_back('{'{0, 0, 0, 0, 0, 4 << 16, 0, 0, 1 << 16}, 1'b0});
        tab.push_back('{'{0, 0, 0, 0, 0, 4 << 16, 0, 0, 0}, 1'b0});
        tab.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1 << 16, 0}, 1'b0});
        tab.push_back('{'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                          32'sh7FFF_FFFF}, 1'b0});
        tab.push_back('{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0,
                          32'sh8000_0000, 32'sh7FFF_FFFF, 1}, 1'b0});
        tab.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1, 0, 0,
                          -1, -1, -1}, 1'b0});
        tab.push_back('{'{-1, -1, -1, 1, 1, 1, 1, -1, 0}, 1'b0});
        tab.push_back('{'{0, 0, 0, 1, 0, 0, 0, 1, 0}, 1'b0});
        tab.push_back('{'{100 << 16, 0, 0, -100 << 16, 0, 0, 0, -1 << 16, 0}, 1'b0});
        // Tie on rounding and saturation of row 3 with a far eye.
        tab.push_back('{'{32'sh7FFF_0000, 32'sh7FFF_0000, 32'sh7FFF_0000, 32'sh7FFF_0000, 0,
                          0, 0, 1 << 16, 1 << 16}, 1'b0});
        tab.push_back('{'{32'sh0000_8000, 32'sh0001_8000, 32'sh0002_8000, 32'sh0003_8000,
                          0, 0, 32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000}, 1'b0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (tab[k]) send_cam(tab[k], 1'b0, 1'b0);

        quiet = 1'b0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
            kind = $urandom_range(0, 9);
            kind = kind < 4 ? 0 : kind < 7 ? 1 : kind < 9 ? 2 : 3;
            c.zero_mat = 1'b0;
            for (int i = 0; i < 9; i++) c.v[i] = rnd_field(kind);
            // Now and then reuse the eye as target or align up with the view direction.
            if ($urandom_range(0, 19) == 0) for (int i = 0; i < 3; i++) c.v[3 + i] = c.v[i];
            if ($urandom_range(0, 19) == 0) begin
                for (int i = 0; i < 3; i++) c.v[6 + i] = c.v[3 + i] - c.v[i];
            end
            send_cam(c, quiet, n == N_RANDOM - 1);
        end

        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (n_err == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: look_at_view_matrix_core.f
hdl/lav_pkg.sv
hdl/lav_norm.sv
hdl/lav_rows.sv
hdl/look_at_view_matrix_core.sv
test/tb.sv
